>>> sv/tmm_pkg.sv
// Shared types and constants for the tile matrix multiply block.
// Depends on nothing; imported by the top level.
package tmm_pkg;

   // Request kinds carried on req_type.
   localparam logic [1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [1:0] REQ_LOAD_BT = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   // Field widths fixed by the interface.
   localparam int IDX_W   = 6;
   localparam int ELEM_W  = 16;
   localparam int VALUE_W = 40;
   localparam int LEN_REG_W = 7;

   // Register map: word index of each configuration register.
   localparam logic REG_INNER_LENGTH = 1'b0;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COL_START,
      ST_ISSUE,
      ST_FINISH
   } tmm_state_type;

endpackage

>>> sv/tmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tile_matrix_multiply.sv
// Tile matrix multiply: a load request writes one element; a compute request emits
// TILE results, one per column, with len = min(inner_length, MAX_K), each set by one
// multiply-accumulate reading both element RAMs one k position per cycle.
// Output backpressure adds cycles per column.
// Synchronous reset clears the sequencer and output valid and sets inner_length to 64;
// the element stores hold no defined value until written.
module tile_matrix_multiply
   import tmm_pkg::*;
#(
   parameter int TILE  = 64,
   parameter int MAX_K = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_type,
   input  logic [IDX_W-1:0]            req_row_index,
   input  logic [IDX_W-1:0]            req_k_index,
   input  logic signed [ELEM_W-1:0]    req_element,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [IDX_W-1:0]            rsp_out_row,
   output logic [IDX_W-1:0]            rsp_out_col,
   output logic signed [VALUE_W-1:0]   rsp_out_value,
   output logic                        rsp_last_of_row,
   // Configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int DEPTH = TILE * MAX_K;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (TILE > 1) ? $clog2(TILE) : 1;
   localparam int LEN_W = $clog2(MAX_K + 1);
   localparam int ACC_W = 33 + $clog2(MAX_K);
   localparam int SW    = (ACC_W > VALUE_W) ? ACC_W : VALUE_W;

   tmm_state_type state_ff, state_in;

   logic [LEN_REG_W-1:0]     inner_length_ff;
   logic [LEN_W-1:0]         len_eff;
   logic [IDX_W-1:0]         row_ff;
   logic [CW-1:0]            col_ff, col_in;
   logic [LEN_W-1:0]         k_ff, k_in;
   logic                     issue;
   logic                     acc_clear;
   logic                     emit;
   logic                     req_accept;
   logic                     load_a_en, load_bt_en, start;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr_a, rd_addr_bt;
   logic [ELEM_W-1:0]        a_rd, bt_rd;
   logic                     rd_valid_ff;
   logic                     p_valid_ff;
   logic signed [31:0]       prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [SW-1:0]     acc_wide;
   logic signed [SW-1:0]     sat_max, sat_min;
   logic signed [VALUE_W-1:0] sat_value;
   logic                     last_col;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     csr_write;

   // Configuration register and read-back.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_length_ff <= LEN_REG_W'(64);
      end else if (csr_write && (csr_paddr[2] == REG_INNER_LENGTH)) begin
         inner_length_ff <= csr_pwdata[LEN_REG_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_INNER_LENGTH) begin
         csr_prdata = 32'(inner_length_ff);
      end
   end

   // Inner length clamped to the store depth.
   assign len_eff = (32'(inner_length_ff) > MAX_K) ? LEN_W'(MAX_K) : LEN_W'(inner_length_ff);

   // Request decode; requests are taken only while the sequencer is idle.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign load_a_en  = req_accept && (req_type == REQ_LOAD_A) &&
                       (32'(req_row_index) < TILE) && (32'(req_k_index) < MAX_K);
   assign load_bt_en = req_accept && (req_type == REQ_LOAD_BT) &&
                       (32'(req_row_index) < TILE) && (32'(req_k_index) < MAX_K);
   assign start      = req_accept && (req_type == REQ_COMPUTE) && (32'(req_row_index) < TILE);
   assign wr_addr    = AW'(32'(req_row_index) * MAX_K + 32'(req_k_index));

   // Read addresses: A row is fixed for the request, B row walks the columns.
   assign rd_addr_a  = AW'(32'(row_ff) * MAX_K + 32'(k_ff));
   assign rd_addr_bt = AW'(32'(col_ff) * MAX_K + 32'(k_ff));

   tmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (load_a_en),
      .wr_addr (wr_addr),
      .wr_data (req_element),
      .rd_en   (issue),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd)
   );

   tmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_bt_store (
      .clock   (clock),
      .wr_en   (load_bt_en),
      .wr_addr (wr_addr),
      .wr_data (req_element),
      .rd_en   (issue),
      .rd_addr (rd_addr_bt),
      .rd_data (bt_rd)
   );

   assign last_col = (32'(col_ff) == TILE - 1);

   // Sequencer: per column clear, issue len reads, drain, then emit one result.
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      k_in      = k_ff;
      issue     = 1'b0;
      acc_clear = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               col_in   = '0;
               state_in = ST_COL_START;
            end
         end
         ST_COL_START: begin
            acc_clear = 1'b1;
            k_in      = '0;
            if (len_eff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            k_in  = k_ff + LEN_W'(1);
            if (k_ff == len_eff - LEN_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rd_valid_ff && !p_valid_ff && (!rsp_valid_ff || !rsp_stall)) begin
               emit = 1'b1;
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + CW'(1);
                  state_in = ST_COL_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
         p_valid_ff  <= rd_valid_ff;
      end
   end

   // Counters and compute row.
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      k_ff   <= k_in;
      if (start) begin
         row_ff <= req_row_index;
      end
   end

   // Multiply stage, then exact accumulation.
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prod_ff <= 32'($signed(a_rd) * $signed(bt_rd));
      end
      if (acc_clear) begin
         acc_ff <= '0;
      end else if (p_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Saturate the sum to the 40-bit result range.
   always_comb begin
      acc_wide = SW'(acc_ff);
      sat_max  = {{(SW - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
      sat_min  = {{(SW - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};
      if (acc_wide > sat_max) begin
         sat_value = sat_max[VALUE_W-1:0];
      end else if (acc_wide < sat_min) begin
         sat_value = sat_min[VALUE_W-1:0];
      end else begin
         sat_value = acc_wide[VALUE_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= IDX_W'(col_ff);
         rsp_value_ff <= sat_value;
         rsp_last_ff  <= last_col;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_last_of_row = rsp_last_ff;

   // A result is only loaded once every product of its column has been summed.
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rd_valid_ff && !p_valid_ff))
      else $error("result emitted before the multiply pipeline drained");

   // Reads never run past the clamped inner length.
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (k_ff < len_eff))
      else $error("read issued beyond inner length");

   // The final column's result ends the request.
   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      (emit && last_col) |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("row did not end after its last column");

   // A valid compute request starts the column loop on the next cycle.
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_COL_START) && (col_ff == '0))
      else $error("compute request did not start the sequencer");

   // Products only appear while a row is in progress.
   a_no_stray_products: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == ST_ISSUE || state_ff == ST_FINISH))
      else $error("product valid outside a compute request");

endmodule
